// ----- src/gnnr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnnr_pkg
// Shared types, constants and helpers of the nearest-neighbour gray resizer.
// ----------------------------------------------------------------------------
package gnnr_pkg;

  // Frame store geometry
  localparam int MAX_PIXELS   = 65536;
  localparam int ADDR_W       = $clog2(MAX_PIXELS);
  localparam int MAX_CHANNELS = 4;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int CH_W    = 3;
  localparam int SUM_W   = 10;
  localparam int GRAY_W  = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd4;

  localparam logic [DIM_W-1:0] RESET_DIM      = 9'd28;
  localparam logic [CH_W-1:0]  RESET_CHANNELS = 3'd1;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Shared divider: dividend wide enough for sum << 16
  localparam int DIV_N_W   = SUM_W + 16;
  localparam int DIV_D_W   = SUM_W;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // 1.0 in Q1.16
  localparam logic [GRAY_W-1:0] ONE_Q16 = 17'h10000;

  // Divider operand selection
  typedef enum logic [1:0] {
    DIV_SEL_X    = 2'd0,
    DIV_SEL_Y    = 2'd1,
    DIV_SEL_NORM = 2'd2
  } div_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;       // write a source pixel beat
    logic     capture;    // latch read coordinates
    logic     div_start;  // launch the divider
    div_sel_t div_sel;    // divider operands
    logic     take_sx;    // store column quotient
    logic     take_sy;    // store row quotient
    logic     mem_rd;     // read the frame store
    logic     push;       // load the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic oor_now;   // coordinate on the input lies outside the destination
    logic div_done;  // divider quotient ready
    logic out_busy;  // output register full and not being taken
  } ctrl_sts_t;

  // Channel count clamped to 1..MAX_CHANNELS
  function automatic logic [CH_W-1:0] eff_channels(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] res;
    if (ch == '0) res = CH_W'(1);
    else if (ch > CH_W'(MAX_CHANNELS)) res = CH_W'(MAX_CHANNELS);
    else res = ch;
    return res;
  endfunction

endpackage : gnnr_pkg
`default_nettype wire

// ----- src/gnnr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnnr_in_if / gnnr_out_if
// Valid/ready stream channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface gnnr_in_if;
  import gnnr_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [BYTE_W-1:0]  chan_a;
  logic [BYTE_W-1:0]  chan_b;
  logic [BYTE_W-1:0]  chan_c;
  logic [BYTE_W-1:0]  chan_d;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;

  modport source (output valid, kind, chan_a, chan_b, chan_c, chan_d, dest_x, dest_y,
                  input ready);
  modport sink   (input valid, kind, chan_a, chan_b, chan_c, chan_d, dest_x, dest_y,
                  output ready);
endinterface : gnnr_in_if

interface gnnr_out_if;
  import gnnr_pkg::*;
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray;
  logic              out_of_range;

  modport source (output valid, gray, out_of_range, input ready);
  modport sink   (input valid, gray, out_of_range, output ready);
endinterface : gnnr_out_if
`default_nettype wire

// ----- src/gray_nearest_neighbor_resizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gray_nearest_neighbor_resizer
// Nearest-neighbour gray scaler over a 64K-entry frame store.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries request beats. kind = load writes the sum of the first
//   channels bytes into the frame store at the write pointer, which wraps
//   after src_width*src_height pixels (64K if zero or larger); kind = read
//   asks for destination pixel (dest_x, dest_y).
//   out_ch carries one result beat per read: gray in Q1.16 and out_of_range.
//   cfg_we/cfg_index/cfg_wdata write the size and channel registers; write
//   them only while no read is in flight.
// Sequencing:
//   A load is written while idle. A read runs three divisions on one shared
//   bit-serial divider (26 steps each), with a store read before the last.
//   An out-of-range read skips them and goes straight to the output
//   register. One read is worked at a time.
// Reset: configuration returns to 28x28 source and destination, one channel,
//   write pointer 0. The frame store is not cleared; read only what was loaded.
// Stall: a result waits in the output register; loads are still taken, and
//   a following read runs up to its result and holds there until it is free.
// ----------------------------------------------------------------------------
module gray_nearest_neighbor_resizer
  import gnnr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gnnr_in_if.sink                    in_ch,
  gnnr_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer
  gnnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  gnnr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .chan_a       (in_ch.chan_a),
    .chan_b       (in_ch.chan_b),
    .chan_c       (in_ch.chan_c),
    .chan_d       (in_ch.chan_d),
    .dest_x       (in_ch.dest_x),
    .dest_y       (in_ch.dest_y),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .gray         (out_ch.gray),
    .out_of_range (out_ch.out_of_range),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule : gray_nearest_neighbor_resizer
`default_nettype wire

// ----- src/gnnr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnnr_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module gnnr_div
  import gnnr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] dividend,
  input  wire logic [DIV_D_W-1:0] divisor,
  output logic      [DIV_N_W-1:0] quotient,
  output logic                    done
);

  logic [DIV_N_W-1:0]   q_r, q_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   d_r, d_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_D_W:0]     trial;

  // Load operands on start, else one restoring step while busy
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DIV_N_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = DIV_D_W'(trial - {1'b0, d_r});
        q_nxt   = {q_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_D_W-1:0];
        q_nxt   = {q_r[DIV_N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule : gnnr_div
`default_nettype wire

// ----- src/gnnr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnnr_dp
// Datapath: configuration, write pointer, frame store, divider, result register.
// ----------------------------------------------------------------------------
module gnnr_dp
  import gnnr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // request payload
  input  wire logic [BYTE_W-1:0]     chan_a,
  input  wire logic [BYTE_W-1:0]     chan_b,
  input  wire logic [BYTE_W-1:0]     chan_c,
  input  wire logic [BYTE_W-1:0]     chan_d,
  input  wire logic [COORD_W-1:0]    dest_x,
  input  wire logic [COORD_W-1:0]    dest_y,
  // result
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic      [GRAY_W-1:0]     gray,
  output logic                       out_of_range,
  // control
  input  wire ctrl_cmd_t             cmd,
  output ctrl_sts_t                  sts
);

  // Configuration registers
  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [CH_W-1:0]  ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RESET_DIM;
      src_h_r <= RESET_DIM;
      ch_r    <= RESET_CHANNELS;
      dst_w_r <= RESET_DIM;
      dst_h_r <= RESET_DIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        CFG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        CFG_CHANNELS:   ch_r    <= cfg_wdata[CH_W-1:0];
        CFG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        CFG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CH_W-1:0] eff_ch;
  assign eff_ch = eff_channels(ch_r);

  // Load path: channel sum and wrapping write pointer
  logic [SUM_W-1:0]  load_sum;
  logic [2*DIM_W-1:0] frame_prod;
  logic [ADDR_W:0]   limit, wr_idx, wr_inc;
  logic [ADDR_W-1:0] wp_r, wp_nxt;

  always_comb begin
    load_sum = {2'd0, chan_a};
    if (eff_ch >= CH_W'(2)) load_sum = load_sum + {2'd0, chan_b};
    if (eff_ch >= CH_W'(3)) load_sum = load_sum + {2'd0, chan_c};
    if (eff_ch >= CH_W'(4)) load_sum = load_sum + {2'd0, chan_d};
  end

  assign frame_prod = {{DIM_W{1'b0}}, src_w_r} * {{DIM_W{1'b0}}, src_h_r};

  always_comb begin
    if (frame_prod == '0 || frame_prod > (2*DIM_W)'(MAX_PIXELS))
      limit = (ADDR_W+1)'(MAX_PIXELS);
    else
      limit = frame_prod[ADDR_W:0];
    wr_idx = ({1'b0, wp_r} >= limit) ? '0 : {1'b0, wp_r};
    wr_inc = wr_idx + (ADDR_W+1)'(1);
    wp_nxt = (wr_inc >= limit) ? '0 : wr_inc[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wp_r <= '0;
    else if (cmd.load) wp_r <= wp_nxt;
  end

  // Read request registers
  logic [COORD_W-1:0] x_r, y_r;
  logic               oor_r;
  logic [DIM_W-1:0]   sx_r, sy_r;
  logic [DIV_N_W-1:0] quot;
  logic               oor_now;

  assign oor_now = ({1'b0, dest_x} >= dst_w_r) || ({1'b0, dest_y} >= dst_h_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= dest_x;
      y_r   <= dest_y;
      oor_r <= oor_now;
    end
    if (cmd.take_sx) sx_r <= quot[DIM_W-1:0];
    if (cmd.take_sy) sy_r <= quot[DIM_W-1:0];
  end

  // Frame store
  logic [SUM_W-1:0]   mem [MAX_PIXELS];
  logic [SUM_W-1:0]   rd_data_r;
  logic [2*DIM_W-1:0] rd_full;
  logic [ADDR_W-1:0]  rd_addr;

  assign rd_full = {{DIM_W{1'b0}}, sy_r} * {{DIM_W{1'b0}}, src_w_r}
                 + {{DIM_W{1'b0}}, sx_r};
  assign rd_addr = rd_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) mem[wr_idx[ADDR_W-1:0]] <= load_sum;
    if (cmd.mem_rd) rd_data_r <= mem[rd_addr];
  end

  // Divider operands
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIM_W+COORD_W-1:0] x_prod, y_prod;
  logic [DIV_D_W:0]   norm_d;
  logic               div_done;

  assign x_prod = {{DIM_W{1'b0}}, x_r} * {{COORD_W{1'b0}}, src_w_r};
  assign y_prod = {{DIM_W{1'b0}}, y_r} * {{COORD_W{1'b0}}, src_h_r};
  // channels * 255
  assign norm_d = {eff_ch, 8'd0} - {{(DIV_D_W+1-CH_W){1'b0}}, eff_ch};

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEL_X: begin
        div_n = DIV_N_W'(x_prod);
        div_d = DIV_D_W'(dst_w_r);
      end
      DIV_SEL_Y: begin
        div_n = DIV_N_W'(y_prod);
        div_d = DIV_D_W'(dst_h_r);
      end
      DIV_SEL_NORM: begin
        div_n = {rd_data_r, 16'd0};
        div_d = norm_d[DIV_D_W-1:0];
      end
      default: begin
        div_n = '0;
        div_d = '1;
      end
    endcase
  end

  gnnr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (quot),
    .done     (div_done)
  );

  // Output register, saturated at 1.0, zero when out of range
  logic              out_valid_r;
  logic [GRAY_W-1:0] gray_r, gray_nxt;
  logic              oor_out_r;
  logic              out_busy;

  always_comb begin
    if (oor_r) gray_nxt = '0;
    else if (quot > DIV_N_W'(ONE_Q16)) gray_nxt = ONE_Q16;
    else gray_nxt = quot[GRAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.push) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      gray_r    <= gray_nxt;
      oor_out_r <= oor_r;
    end
  end

  assign out_busy     = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign gray         = gray_r;
  assign out_of_range = oor_out_r;

  // Status back to the controller
  assign sts = '{oor_now: oor_now, div_done: div_done, out_busy: out_busy};

endmodule : gnnr_dp
`default_nettype wire

// ----- src/gnnr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnnr_ctrl
// Controller: sequences loads, coordinate scaling, store read and normalising.
// ----------------------------------------------------------------------------
module gnnr_ctrl
  import gnnr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_kind,
  output logic           in_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_XGO   = 9'b000000010,
    S_XWAIT = 9'b000000100,
    S_YGO   = 9'b000001000,
    S_YWAIT = 9'b000010000,
    S_RDMEM = 9'b000100000,
    S_NGO   = 9'b001000000,
    S_NWAIT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = DIV_SEL_X;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = sts.oor_now ? S_DONE : S_XGO;
          end
        end
      end
      S_XGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_X;
        state_nxt     = S_XWAIT;
      end
      S_XWAIT: begin
        if (sts.div_done) begin
          cmd.take_sx = 1'b1;
          state_nxt   = S_YGO;
        end
      end
      S_YGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_Y;
        state_nxt     = S_YWAIT;
      end
      S_YWAIT: begin
        if (sts.div_done) begin
          cmd.take_sy = 1'b1;
          state_nxt   = S_RDMEM;
        end
      end
      S_RDMEM: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_NGO;
      end
      S_NGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_NORM;
        state_nxt     = S_NWAIT;
      end
      S_NWAIT: begin
        if (sts.div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule : gnnr_ctrl
`default_nettype wire
